[design/seg_soft_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package seg_soft_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_MASTER_VOLUME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOFTEN_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEREO_MODE   = 2'd2;

    localparam logic [CFG_DATA_W-1:0] VOLUME_RESET = 9'd128;
    localparam logic [CFG_DATA_W-1:0] VOLUME_MAX   = 9'd256;
    localparam logic                  SOFTEN_RESET = 1'b0;
    localparam logic                  STEREO_RESET = 1'b1;

    // Output limits
    localparam int SAT16_MIN = -32768;
    localparam int SAT16_MAX = 32767;
    localparam int MONO_MIN  = -65536;
    localparam int MONO_MAX  = 65535;

    // Smoothing filter: taps sum to this divisor.
    localparam int DIVISOR     = 9;
    // Register stages inside the divide-by-nine unit.
    localparam int DIV_LATENCY = 8;

    // Samples taken so far in the current segment, saturating.
    typedef enum logic [1:0] {
        POS_START,
        POS_ONE,
        POS_RUN
    } seg_pos_t;

endpackage

`default_nettype wire

[design/audio_segment_soften_saturate_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Volume, optional five-tap smoothing, optional mono mix and 16-bit
// saturation of a stereo stream split into segments. One left/right pair is
// taken every cycle while the output side keeps up; the pair that carries
// segment_end holds off the input while the window drains the last results
// of the segment. Results trail the input by two samples. The transfer itself
// loads the scaled input register; a result then passes through the tap
// adder register, the divide-by-nine pipeline and the output register, and
// the drained results of a segment end take the same path. A stalled output
// stalls the whole pipeline. After reset the volume is 128, smoothing is off,
// output is stereo and a new segment begins. Configuration may change only
// while the block is empty.
module audio_segment_soften_saturate_unit #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,

    input  wire logic                                      cfg_write,
    input  wire logic [seg_soft_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [seg_soft_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  wire logic                                      in_valid,
    output logic                                           in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]            left_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0]            right_sample,
    input  wire logic                                      segment_end,

    output logic                                           out_valid,
    input  wire logic                                      out_ready,
    output logic signed [15:0]                             left_out,
    output logic signed [15:0]                             right_out,
    output logic                                           last_of_segment
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int SUM_W  = SW + 4;
    localparam int VOL_W  = seg_soft_pkg::CFG_DATA_W;
    localparam int PROD_W = SW + VOL_W + 1;
    localparam int MIX_W  = SW + 1;
    localparam int LAT    = seg_soft_pkg::DIV_LATENCY;

    localparam logic signed [SW-1:0]    LO16 = SW'(seg_soft_pkg::SAT16_MIN);
    localparam logic signed [SW-1:0]    HI16 = SW'(seg_soft_pkg::SAT16_MAX);
    localparam logic signed [MIX_W-1:0] LO_MIX = MIX_W'(seg_soft_pkg::MONO_MIN);
    localparam logic signed [MIX_W-1:0] HI_MIX = MIX_W'(seg_soft_pkg::MONO_MAX);

    // Configuration registers
    logic [VOL_W-1:0] volume_reg;
    logic             soften_reg;
    logic             stereo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= seg_soft_pkg::VOLUME_RESET;
            soften_reg <= seg_soft_pkg::SOFTEN_RESET;
            stereo_reg <= seg_soft_pkg::STEREO_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                seg_soft_pkg::REG_MASTER_VOLUME: volume_reg <= cfg_data;
                seg_soft_pkg::REG_SOFTEN_ENABLE: soften_reg <= cfg_data[0];
                seg_soft_pkg::REG_STEREO_MODE:   stereo_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Volume scaling at the input register
    logic [VOL_W-1:0]         vol_eff;
    logic signed [PROD_W-1:0] prod_l, prod_r;

    assign vol_eff = (volume_reg > seg_soft_pkg::VOLUME_MAX) ? seg_soft_pkg::VOLUME_MAX
                                                             : volume_reg;
    assign prod_l  = left_sample * $signed({1'b0, vol_eff});
    assign prod_r  = right_sample * $signed({1'b0, vol_eff});

    logic                 s0_valid_reg, s0_valid_next;
    logic                 s0_end_reg;
    logic signed [SW-1:0] s0_left_reg, s0_right_reg;

    logic adv, flush_active, seq_take, take, in_xfer;

    logic [1:0] flush_left_reg, flush_left_next;

    assign adv          = !out_valid || out_ready;
    assign flush_active = (flush_left_reg != 2'd0);
    assign seq_take     = adv && !flush_active;
    assign in_ready     = seq_take || !s0_valid_reg;
    assign take         = seq_take && s0_valid_reg;
    assign in_xfer      = in_valid && in_ready;

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (in_xfer)
            s0_valid_next = 1'b1;
        else if (take)
            s0_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= s0_valid_next;
    end

    // The arithmetic shift right by eight is a floor, so the scaled value is
    // simply the product with its low eight bits dropped.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s0_left_reg  <= prod_l[SW+7:8];
            s0_right_reg <= prod_r[SW+7:8];
            s0_end_reg   <= segment_end;
        end
    end

    // Segment window and sequencer
    seg_soft_pkg::seg_pos_t pos_reg, pos_next;

    logic signed [SW-1:0] lwin_reg [4];
    logic signed [SW-1:0] rwin_reg [4];
    logic signed [SW-1:0] lwin_next [4];
    logic signed [SW-1:0] rwin_next [4];
    logic signed [SW-1:0] nxt_l, nxt_r;
    logic                 emit, emit_last;

    always_comb
    begin
        pos_next        = pos_reg;
        flush_left_next = flush_left_reg;
        lwin_next       = lwin_reg;
        rwin_next       = rwin_reg;
        emit            = 1'b0;
        emit_last       = 1'b0;
        nxt_l           = s0_left_reg;
        nxt_r           = s0_right_reg;

        if (take)
        begin
            unique case (pos_reg)
                seg_soft_pkg::POS_START:
                begin
                    // The first sample fills every tap of the window.
                    lwin_next       = '{s0_left_reg, s0_left_reg, s0_left_reg, s0_left_reg};
                    rwin_next       = '{s0_right_reg, s0_right_reg, s0_right_reg,
                                        s0_right_reg};
                    pos_next        = s0_end_reg ? seg_soft_pkg::POS_START
                                                 : seg_soft_pkg::POS_ONE;
                    flush_left_next = s0_end_reg ? 2'd1 : 2'd0;
                end
                seg_soft_pkg::POS_ONE,
                seg_soft_pkg::POS_RUN:
                begin
                    emit            = (pos_reg == seg_soft_pkg::POS_RUN);
                    lwin_next       = '{lwin_reg[1], lwin_reg[2], lwin_reg[3], s0_left_reg};
                    rwin_next       = '{rwin_reg[1], rwin_reg[2], rwin_reg[3], s0_right_reg};
                    pos_next        = s0_end_reg ? seg_soft_pkg::POS_START
                                                 : seg_soft_pkg::POS_RUN;
                    flush_left_next = s0_end_reg ? 2'd2 : 2'd0;
                end
                default:
                begin
                    pos_next = seg_soft_pkg::POS_START;
                end
            endcase
        end
        else if (adv && flush_active)
        begin
            // While draining, the newest tap already holds the segment's last
            // sample, and it also stands in for every tap past the end.
            emit      = 1'b1;
            emit_last = (flush_left_reg == 2'd1);
            nxt_l     = lwin_reg[3];
            nxt_r     = rwin_reg[3];
            if (flush_left_reg == 2'd2)
            begin
                lwin_next = '{lwin_reg[1], lwin_reg[2], lwin_reg[3], lwin_reg[3]};
                rwin_next = '{rwin_reg[1], rwin_reg[2], rwin_reg[3], rwin_reg[3]};
            end
            flush_left_next = flush_left_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= seg_soft_pkg::POS_START;
            flush_left_reg <= 2'd0;
            lwin_reg       <= '{default: '0};
            rwin_reg       <= '{default: '0};
        end
        else
        begin
            pos_reg        <= pos_next;
            flush_left_reg <= flush_left_next;
            lwin_reg       <= lwin_next;
            rwin_reg       <= rwin_next;
        end
    end

    // Tap sum: weights 1,2,3,2,1 from oldest to newest; with smoothing off, the centre tap alone.
    function automatic logic signed [SUM_W-1:0] tap_sum(
        input logic signed [SW-1:0] w0,
        input logic signed [SW-1:0] w1,
        input logic signed [SW-1:0] w2,
        input logic signed [SW-1:0] w3,
        input logic signed [SW-1:0] nx,
        input logic                 smooth_on
    );
        logic signed [SUM_W-1:0] e0, e1, e2, e3, e4;
        begin
            e0 = SUM_W'(w0);
            e1 = SUM_W'(w1);
            e2 = SUM_W'(w2);
            e3 = SUM_W'(w3);
            e4 = SUM_W'(nx);
            if (smooth_on)
                tap_sum = (e2 <<< 1) + e2 + ((e1 + e3) <<< 1) + e0 + e4;
            else
                tap_sum = e2;
        end
    endfunction

    logic                    p1_valid_reg, p1_last_reg;
    logic signed [SUM_W-1:0] p1_sum_l_reg, p1_sum_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= emit;
            p1_last_reg  <= emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_sum_l_reg <= tap_sum(lwin_reg[0], lwin_reg[1], lwin_reg[2], lwin_reg[3],
                                    nxt_l, soften_reg);
            p1_sum_r_reg <= tap_sum(rwin_reg[0], rwin_reg[1], rwin_reg[2], rwin_reg[3],
                                    nxt_r, soften_reg);
        end
    end

    // Divide by nine
    logic signed [SW-1:0] filt_l, filt_r;

    seg_soft_div9 #(
        .SAMPLE_WIDTH (SW)
    ) u_div_left (
        .clk       (clk),
        .en        (adv),
        .smooth_on (soften_reg),
        .sum       (p1_sum_l_reg),
        .result    (filt_l)
    );

    seg_soft_div9 #(
        .SAMPLE_WIDTH (SW)
    ) u_div_right (
        .clk       (clk),
        .en        (adv),
        .smooth_on (soften_reg),
        .sum       (p1_sum_r_reg),
        .result    (filt_r)
    );

    logic vpipe_reg [LAT];
    logic lpipe_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpipe_reg <= '{default: 1'b0};
            lpipe_reg <= '{default: 1'b0};
        end
        else if (adv)
        begin
            vpipe_reg[0] <= p1_valid_reg;
            lpipe_reg[0] <= p1_last_reg;
            for (int i = 1; i < LAT; i++)
            begin
                vpipe_reg[i] <= vpipe_reg[i-1];
                lpipe_reg[i] <= lpipe_reg[i-1];
            end
        end
    end

    // Saturation and mono mix
    logic signed [MIX_W-1:0] mix;
    logic signed [MIX_W-1:0] mix_half;
    logic signed [15:0]      left_res, right_res, sat_l, sat_r, mono;

    always_comb
    begin
        if (filt_l < LO16)
            sat_l = 16'sh8000;
        else if (filt_l > HI16)
            sat_l = 16'sh7FFF;
        else
            sat_l = filt_l[15:0];

        if (filt_r < LO16)
            sat_r = 16'sh8000;
        else if (filt_r > HI16)
            sat_r = 16'sh7FFF;
        else
            sat_r = filt_r[15:0];

        mix      = MIX_W'(filt_l) + MIX_W'(filt_r);
        mix_half = mix >>> 1;
        if (mix < LO_MIX)
            mono = 16'sh8000;
        else if (mix > HI_MIX)
            mono = 16'sh7FFF;
        else
            mono = mix_half[15:0];

        left_res  = stereo_reg ? sat_l : mono;
        right_res = stereo_reg ? sat_r : mono;
    end

    logic               out_valid_reg, out_last_reg;
    logic signed [15:0] out_left_reg, out_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vpipe_reg[LAT-1];
            out_last_reg  <= lpipe_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_left_reg  <= left_res;
            out_right_reg <= right_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign left_out        = out_left_reg;
    assign right_out       = out_right_reg;
    assign last_of_segment = out_last_reg;

    // A drain is only pending once the segment has been closed.
    a_flush_closes_segment: assert property (@(posedge clk) disable iff (!rst_n)
        flush_active |-> (pos_reg == seg_soft_pkg::POS_START))
        else $error("drain pending while a segment is open");

    a_flush_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        flush_left_reg != 2'd3)
        else $error("drain count out of range");

    a_end_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s0_end_reg) |=> flush_active)
        else $error("segment end transfer did not start a drain");

    a_start_fills_window: assert property (@(posedge clk) disable iff (!rst_n)
        (take && pos_reg == seg_soft_pkg::POS_START) |=>
            (lwin_reg[0] == lwin_reg[3] && lwin_reg[1] == lwin_reg[2] &&
             lwin_reg[0] == lwin_reg[1] && rwin_reg[0] == rwin_reg[3] &&
             rwin_reg[1] == rwin_reg[2] && rwin_reg[0] == rwin_reg[1]))
        else $error("segment start did not fill the window");

    a_no_emit_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> (!take && !emit))
        else $error("sequencer moved while the output was stalled");

endmodule

`default_nettype wire

[design/seg_soft_div9.sv]
`timescale 1ns / 1ps
`default_nettype none

// Signed divide by nine, truncating toward zero, as an eight-stage pipeline.
// With smooth_on low the magnitude passes through undivided, so the unit then
// just delays the (narrowed) input.
module seg_soft_div9 #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic                          smooth_on,
    input  wire logic signed [SAMPLE_WIDTH+3:0] sum,
    output logic signed [SAMPLE_WIDTH-1:0]     result
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int SUM_W = SW + 4;
    localparam int MAG_W = SW + 3;
    localparam int FRAC  = 4;
    localparam int Y_W   = MAG_W + 4 + FRAC;

    logic [SUM_W-1:0] sum_abs;
    logic [MAG_W+3:0] times7;
    logic [Y_W-1:0]   t_last;
    logic [SUM_W-1:0] rem;
    logic [SW-1:0]    q_fixed;

    logic             neg_d1_reg, neg_d2_reg, neg_d3_reg, neg_d4_reg;
    logic             neg_d5_reg, neg_d6_reg, neg_d7_reg;
    logic [MAG_W-1:0] mag_d1_reg, mag_d2_reg, mag_d3_reg, mag_d4_reg;
    logic [MAG_W-1:0] mag_d5_reg, mag_d6_reg;
    logic [Y_W-1:0]   y_d2_reg, t_d3_reg, t_d4_reg;
    logic [SW-1:0]    qe_d5_reg, qe_d6_reg;
    logic [SUM_W-1:0] nq_d6_reg;
    logic [SW-1:0]    val_d7_reg;
    logic [SW-1:0]    result_reg;

    // x/9 = 7x/63, and 1/63 = 2^-6 * (1 + 2^-6)(1 + 2^-12)(1 + 2^-24)...
    // The product is cut short and truncated, so the estimate can come out
    // one below the true quotient; the remainder check fixes that.
    always_comb
    begin
        sum_abs = sum[SUM_W-1] ? -sum : sum;
        times7  = {1'b0, mag_d1_reg, 3'b000} - {4'b0000, mag_d1_reg};
        t_last  = t_d4_reg + (t_d4_reg >> 24);
        rem     = {1'b0, mag_d6_reg} - nq_d6_reg;
        q_fixed = (rem >= SUM_W'(seg_soft_pkg::DIVISOR)) ? qe_d6_reg + 1'b1 : qe_d6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_d1_reg <= sum[SUM_W-1];
            mag_d1_reg <= sum_abs[MAG_W-1:0];

            neg_d2_reg <= neg_d1_reg;
            mag_d2_reg <= mag_d1_reg;
            y_d2_reg   <= {times7, {FRAC{1'b0}}};

            neg_d3_reg <= neg_d2_reg;
            mag_d3_reg <= mag_d2_reg;
            t_d3_reg   <= y_d2_reg + (y_d2_reg >> 6);

            neg_d4_reg <= neg_d3_reg;
            mag_d4_reg <= mag_d3_reg;
            t_d4_reg   <= t_d3_reg + (t_d3_reg >> 12);

            neg_d5_reg <= neg_d4_reg;
            mag_d5_reg <= mag_d4_reg;
            qe_d5_reg  <= t_last[FRAC+6 +: SW];

            neg_d6_reg <= neg_d5_reg;
            mag_d6_reg <= mag_d5_reg;
            qe_d6_reg  <= qe_d5_reg;
            nq_d6_reg  <= {1'b0, qe_d5_reg, 3'b000} + {4'b0000, qe_d5_reg};

            neg_d7_reg <= neg_d6_reg;
            val_d7_reg <= smooth_on ? q_fixed : mag_d6_reg[SW-1:0];

            result_reg <= neg_d7_reg ? -val_d7_reg : val_d7_reg;
        end
    end

    assign result = $signed(result_reg);

endmodule

`default_nettype wire

[tb/tb_audio_segment_soften_saturate_unit.sv]
`timescale 1ns / 1ps

module tb_audio_segment_soften_saturate_unit;

    localparam int SAMPLE_W     = 24;
    localparam int CFG_IDX_W    = seg_soft_pkg::CFG_INDEX_W;
    localparam int CFG_W        = seg_soft_pkg::CFG_DATA_W;
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = seg_soft_pkg::DIV_LATENCY + 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 50;
    localparam int RAND_PHASES  = 9;
    localparam int PHASE_PAIRS  = 32;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       seg_end;
    } stereo_pair_t;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } out_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;

    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] left_sample = '0;
    logic signed [SAMPLE_W-1:0] right_sample = '0;
    logic                       segment_end = 1'b0;

    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [15:0]         left_out;
    logic signed [15:0]         right_out;
    logic                       last_of_segment;

    stereo_pair_t pair_queue[$];
    out_pair_t    pending_results[$];

    int unsigned queued_cnt = 0;
    int unsigned issued_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned error_cnt = 0;

    bit           idle_on = 1'b0;
    int unsigned  in_gap = 0;
    int unsigned  out_gap = 0;
    logic         next_in_valid;
    logic         next_out_ready;
    stereo_pair_t drv_pair;
    out_pair_t    exp_pair;

    // Predictor state: the scaled sample windows, oldest first.
    longint                 win_l[4];
    longint                 win_r[4];
    seg_soft_pkg::seg_pos_t seg_pos;
    logic [CFG_W-1:0]       vol_reg;
    logic                   soften_reg;
    logic                   stereo_reg;

    audio_segment_soften_saturate_unit #(
        .SAMPLE_WIDTH(SAMPLE_W)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .segment_end    (segment_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_out       (left_out),
        .right_out      (right_out),
        .last_of_segment(last_of_segment)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_cnt++;
        if (error_cnt <= PRINT_LIMIT)
            $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    endtask

    function automatic longint scale_sample(input logic signed [SAMPLE_W-1:0] x);
        longint gain;
        gain = (vol_reg > seg_soft_pkg::VOLUME_MAX) ? longint'(seg_soft_pkg::VOLUME_MAX)
                                                    : longint'(vol_reg);
        return (longint'(x) * gain) >>> 8;
    endfunction

    function automatic longint smooth_tap(input longint w[4], input longint nxt);
        if (!soften_reg)
            return w[2];
        return (3 * w[2] + 2 * w[1] + 2 * w[3] + w[0] + nxt) / seg_soft_pkg::DIVISOR;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v < seg_soft_pkg::SAT16_MIN)
            return 16'sh8000;
        if (v > seg_soft_pkg::SAT16_MAX)
            return 16'sh7FFF;
        return v[15:0];
    endfunction

    function automatic void fill_windows(input longint xl, input longint xr);
        for (int i = 0; i < 4; i++)
        begin
            win_l[i] = xl;
            win_r[i] = xr;
        end
    endfunction

    function automatic void shift_windows(input longint xl, input longint xr);
        for (int i = 0; i < 3; i++)
        begin
            win_l[i] = win_l[i+1];
            win_r[i] = win_r[i+1];
        end
        win_l[3] = xl;
        win_r[3] = xr;
    endfunction

    function automatic void push_expected(input longint nl, input longint nr, input logic last);
        longint    l;
        longint    r;
        longint    s;
        out_pair_t res;
        l = smooth_tap(win_l, nl);
        r = smooth_tap(win_r, nr);
        if (stereo_reg)
        begin
            res.left  = clip16(l);
            res.right = clip16(r);
        end
        else
        begin
            s = l + r;
            if (s < seg_soft_pkg::MONO_MIN)
                res.left = 16'sh8000;
            else if (s > seg_soft_pkg::MONO_MAX)
                res.left = 16'sh7FFF;
            else
                res.left = 16'(s >>> 1);
            res.right = res.left;
        end
        res.last = last;
        pending_results.push_back(res);
    endfunction

    function automatic void soften_predict(input stereo_pair_t p);
        longint xl;
        longint xr;
        xl = scale_sample(p.left);
        xr = scale_sample(p.right);
        if (!p.seg_end)
        begin
            if (seg_pos == seg_soft_pkg::POS_START)
            begin
                fill_windows(xl, xr);
                seg_pos = seg_soft_pkg::POS_ONE;
            end
            else
            begin
                if (seg_pos == seg_soft_pkg::POS_RUN)
                    push_expected(xl, xr, 1'b0);
                shift_windows(xl, xr);
                seg_pos = seg_soft_pkg::POS_RUN;
            end
        end
        else
        begin
            if (seg_pos == seg_soft_pkg::POS_START)
            begin
                fill_windows(xl, xr);
                push_expected(xl, xr, 1'b1);
            end
            else
            begin
                // The end sample repeats itself into the lookahead taps to flush.
                if (seg_pos == seg_soft_pkg::POS_RUN)
                    push_expected(xl, xr, 1'b0);
                shift_windows(xl, xr);
                push_expected(xl, xr, 1'b0);
                shift_windows(xl, xr);
                push_expected(xl, xr, 1'b1);
            end
            seg_pos = seg_soft_pkg::POS_START;
        end
    endfunction

    // Monitor: input transfers feed the predictor, output transfers are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                soften_predict('{left_sample, right_sample, segment_end});
                accepted_cnt <= accepted_cnt + 1;
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result L=%0d R=%0d last=%0b",
                                              left_out, right_out, last_of_segment));
                else
                begin
                    exp_pair = pending_results.pop_front();
                    if (left_out !== exp_pair.left)
                        report_mismatch($sformatf("left_out %0d, expected %0d",
                                                  left_out, exp_pair.left));
                    if (right_out !== exp_pair.right)
                        report_mismatch($sformatf("right_out %0d, expected %0d",
                                                  right_out, exp_pair.right));
                    if (last_of_segment !== exp_pair.last)
                        report_mismatch($sformatf("last_of_segment %0b, expected %0b",
                                                  last_of_segment, exp_pair.last));
                end
            end
        end
    end

    // Input driver: holds a pair until its transfer, otherwise idles or sends the next.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            next_in_valid = in_valid;
            if (in_valid && accepted_cnt != issued_cnt)
                next_in_valid = 1'b1;
            else if (in_gap != 0)
            begin
                in_gap--;
                next_in_valid = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                in_gap = $urandom_range(1, 16) - 1;
                next_in_valid = 1'b0;
            end
            else if (pair_queue.size() != 0)
            begin
                drv_pair = pair_queue.pop_front();
                left_sample  <= drv_pair.left;
                right_sample <= drv_pair.right;
                segment_end  <= drv_pair.seg_end;
                issued_cnt++;
                next_in_valid = 1'b1;
            end
            else
                next_in_valid = 1'b0;
            in_valid <= next_in_valid;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap != 0)
            begin
                out_gap--;
                next_out_ready = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_gap = $urandom_range(1, 16) - 1;
                next_out_ready = 1'b0;
            end
            else
                next_out_ready = 1'b1;
            out_ready <= next_out_ready;
        end
    end

    task automatic push_pair(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r, input logic e);
        pair_queue.push_back('{l, r, e});
        queued_cnt++;
    endtask

    // Items are queued just after a rising edge so the driver never races the push.
    task automatic open_phase(input bit with_idle);
        @(posedge clk);
        idle_on = with_idle;
    endtask

    task automatic drain_block();
        do
            @(negedge clk);
        while (accepted_cnt != queued_cnt || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            seg_soft_pkg::REG_MASTER_VOLUME: vol_reg = val;
            seg_soft_pkg::REG_SOFTEN_ENABLE: soften_reg = val[0];
            seg_soft_pkg::REG_STEREO_MODE:   stereo_reg = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = SAMPLE_W'($urandom);
            3, 4:    v = SAMPLE_W'(int'($urandom_range(0, 131071)) - 65536);
            5:       v = SAMPLE_W'(int'($urandom_range(0, 1048575)) - 524288);
            6:       v = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
            default: v = SAMPLE_W'(int'($urandom_range(0, 2)) - 1);
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] rand_volume();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return seg_soft_pkg::VOLUME_MAX;
            2:       return CFG_W'($urandom_range(257, 511));
            3:       return 9'd1;
            4:       return 9'd255;
            default: return CFG_W'($urandom_range(0, 256));
        endcase
    endfunction

    function automatic int rand_seg_len();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return 2;
            2:       return 3;
            8, 9:    return $urandom_range(13, 30);
            default: return $urandom_range(4, 12);
        endcase
    endfunction

    initial
    begin
        int n;
        int len;
        vol_reg    = seg_soft_pkg::VOLUME_RESET;
        soften_reg = seg_soft_pkg::SOFTEN_RESET;
        stereo_reg = seg_soft_pkg::STEREO_RESET;
        fill_windows(longint'(0), longint'(0));
        seg_pos = seg_soft_pkg::POS_START;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: one, two and three sample segments.
        open_phase(1'b1);
        push_pair(SMP_MAX, SMP_MIN, 1'b1);
        push_pair(SMP_MIN, SMP_MAX, 1'b0);
        push_pair(SMP_MAX, SMP_MIN, 1'b1);
        push_pair('0, -24'sd1, 1'b0);
        push_pair(-24'sd1, '0, 1'b0);
        push_pair(24'sd1, 24'sd1, 1'b1);
        drain_block();

        // Full volume with smoothing across alternating extremes.
        write_reg(seg_soft_pkg::REG_MASTER_VOLUME, seg_soft_pkg::VOLUME_MAX);
        write_reg(seg_soft_pkg::REG_SOFTEN_ENABLE, 9'd1);
        open_phase(1'b1);
        push_pair(SMP_MAX, SMP_MIN, 1'b0);
        push_pair(SMP_MIN, SMP_MAX, 1'b0);
        push_pair(SMP_MAX, SMP_MIN, 1'b0);
        push_pair(SMP_MIN, SMP_MAX, 1'b0);
        push_pair(SMP_MAX, SMP_MIN, 1'b1);
        push_pair(-24'sd1, -24'sd1, 1'b1);
        drain_block();

        // Volume above the maximum saturates; the mono sum clips both ways.
        write_reg(seg_soft_pkg::REG_MASTER_VOLUME, 9'd511);
        write_reg(seg_soft_pkg::REG_STEREO_MODE, 9'd0);
        open_phase(1'b1);
        push_pair(SMP_MAX, SMP_MAX, 1'b0);
        push_pair(SMP_MAX, SMP_MAX, 1'b0);
        push_pair(SMP_MIN, SMP_MIN, 1'b0);
        push_pair(SMP_MIN, SMP_MIN, 1'b1);
        push_pair(SMP_MAX, SMP_MIN, 1'b0);
        push_pair('0, '0, 1'b1);
        drain_block();

        write_reg(seg_soft_pkg::REG_MASTER_VOLUME, '0);
        write_reg(seg_soft_pkg::REG_SOFTEN_ENABLE, 9'd0);
        open_phase(1'b0);
        push_pair(SMP_MAX, SMP_MIN, 1'b0);
        push_pair(SMP_MIN, SMP_MAX, 1'b0);
        push_pair(24'sd12345, -24'sd54321, 1'b0);
        push_pair(-24'sd7, 24'sd7, 1'b1);
        drain_block();

        // Random segments; each phase ends on a segment end so the block is empty.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            write_reg(seg_soft_pkg::REG_MASTER_VOLUME, rand_volume());
            write_reg(seg_soft_pkg::REG_SOFTEN_ENABLE, CFG_W'($urandom_range(0, 1)));
            write_reg(seg_soft_pkg::REG_STEREO_MODE, CFG_W'($urandom_range(0, 1)));
            open_phase(ph != RAND_PHASES - 1 && $urandom_range(0, 3) != 0);
            n = 0;
            while (n < PHASE_PAIRS)
            begin
                len = rand_seg_len();
                for (int k = 0; k < len; k++)
                    push_pair(rand_sample(), rand_sample(), k == len - 1);
                n += len;
            end
            drain_block();
        end

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
